// ===== hw/rtl/dpfa_pkg.sv =====
// dpfa_pkg: sizes, codes, controller/datapath interface structs and pick functions
// for the demand paging frame allocator; no dependencies
package dpfa_pkg;

  // geometry
  localparam int PAGE_BYTES     = 32;
  localparam int FRAMES         = 32;
  localparam int VIRT_BYTES     = 512;
  localparam int PROCS          = 8;
  localparam int PAGES_PER_PROC = (VIRT_BYTES + PAGE_BYTES - 1) / PAGE_BYTES;
  localparam int PT_DEPTH       = PROCS * PAGES_PER_PROC;
  localparam int PHYS_DEPTH     = FRAMES * PAGE_BYTES;

  // field and index widths
  localparam int FUNC_W   = 2;
  localparam int PROC_W   = 3;
  localparam int SIZE_W   = 10;
  localparam int ADDR_W   = 9;
  localparam int BYTE_W   = 8;
  localparam int STAT_W   = 3;
  localparam int FRAME_W  = $clog2(FRAMES);
  localparam int OFF_W    = $clog2(PAGE_BYTES);
  localparam int PAGE_W   = $clog2(PAGES_PER_PROC);
  localparam int PT_AW    = $clog2(PT_DEPTH);
  localparam int PA_W     = $clog2(PHYS_DEPTH);
  localparam int CNT_W    = PA_W;
  localparam int RES_W    = $clog2(FRAMES + 1);
  localparam int IN_DW    = 32;
  localparam int OUT_DW   = 24;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_CREATE = 2'd0;
  localparam logic [FUNC_W-1:0] FN_EXIT   = 2'd1;
  localparam logic [FUNC_W-1:0] FN_READ   = 2'd2;
  localparam logic [FUNC_W-1:0] FN_WRITE  = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_RANGE   = 3'd1;
  localparam logic [STAT_W-1:0] ST_BUDGET  = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOSLOT  = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTRUN  = 3'd4;
  localparam logic [STAT_W-1:0] ST_NOFRAME = 3'd5;

  // controller to datapath commands
  typedef struct packed {
    logic latch;
    logic eval;
    logic map;
    logic walk;
    logic clear;
    logic load;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_exit;
    logic is_rw;
    logic eval_err;
    logic walk_last;
    logic clear_last;
    logic out_full;
  } dp_sts_t;

  // pages covering a byte count
  function automatic logic [RES_W-1:0] pages_for(logic [SIZE_W-1:0] bytes);
    logic [SIZE_W-1:0] m1;
    m1 = bytes - 1'b1;
    if (bytes == '0) begin
      return '0;
    end
    return RES_W'(m1 >> OFF_W) + 1'b1;
  endfunction

  // index of the lowest set bit, frame vector
  function automatic logic [FRAME_W-1:0] lowest_frame(logic [FRAMES-1:0] v);
    logic [FRAMES-1:0]  iso;
    logic [FRAME_W-1:0] idx;
    iso = v & (~v + 1'b1);
    idx = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (iso[i]) idx = idx | FRAME_W'(i);
    end
    return idx;
  endfunction

  // index of the lowest set bit, slot vector
  function automatic logic [PROC_W-1:0] lowest_slot(logic [PROCS-1:0] v);
    logic [PROCS-1:0]  iso;
    logic [PROC_W-1:0] idx;
    iso = v & (~v + 1'b1);
    idx = '0;
    for (int i = 0; i < PROCS; i++) begin
      if (iso[i]) idx = idx | PROC_W'(i);
    end
    return idx;
  endfunction

endpackage

// ===== hw/rtl/dpfa_ctrl.sv =====
// dpfa_ctrl: sequencing state machine of the frame allocator
// depends on dpfa_pkg (command and status structs)
module dpfa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              out_tready,
  input  dpfa_pkg::dp_sts_t sts,
  output dpfa_pkg::dp_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_EVAL  = 6'b000100,
    S_MAP   = 6'b001000,
    S_WALK  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // commands from the current state
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_CLEAR: cmd.clear = 1'b1;
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.latch = in_tvalid;
      end
      S_EVAL:  cmd.eval = 1'b1;
      S_MAP:   cmd.map  = 1'b1;
      S_WALK:  cmd.walk = 1'b1;
      S_DONE:  cmd.load = !sts.out_full || out_tready;
      default: cmd = '0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (sts.clear_last) state_nxt = S_IDLE;
      S_IDLE:  if (in_tvalid) state_nxt = S_EVAL;
      S_EVAL: begin
        if (sts.eval_err || !(sts.is_exit || sts.is_rw)) begin
          state_nxt = S_DONE;
        end else if (sts.is_exit) begin
          state_nxt = S_WALK;
        end else begin
          state_nxt = S_MAP;
        end
      end
      S_MAP:   state_nxt = S_DONE;
      S_WALK:  if (sts.walk_last) state_nxt = S_DONE;
      S_DONE:  if (!sts.out_full || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/dpfa_datapath.sv =====
// dpfa_datapath: process table, page table, frame map, physical store and result register
// depends on dpfa_pkg (sizes, codes, structs, pick functions)
module dpfa_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [dpfa_pkg::IN_DW-1:0]   in_tdata,
  input  logic [dpfa_pkg::FUNC_W-1:0]  in_tuser,
  input  dpfa_pkg::dp_cmd_t            cmd,
  output dpfa_pkg::dp_sts_t            sts,
  input  logic                         out_tready,
  output logic                         out_tvalid,
  output logic [dpfa_pkg::OUT_DW-1:0]  out_tdata
);

  localparam int PROC_W  = dpfa_pkg::PROC_W;
  localparam int SIZE_W  = dpfa_pkg::SIZE_W;
  localparam int ADDR_W  = dpfa_pkg::ADDR_W;
  localparam int BYTE_W  = dpfa_pkg::BYTE_W;
  localparam int STAT_W  = dpfa_pkg::STAT_W;
  localparam int FRAME_W = dpfa_pkg::FRAME_W;
  localparam int OFF_W   = dpfa_pkg::OFF_W;
  localparam int PAGE_W  = dpfa_pkg::PAGE_W;
  localparam int PT_AW   = dpfa_pkg::PT_AW;
  localparam int PA_W    = dpfa_pkg::PA_W;
  localparam int CNT_W   = dpfa_pkg::CNT_W;
  localparam int RES_W   = dpfa_pkg::RES_W;

  // request registers
  logic [dpfa_pkg::FUNC_W-1:0] func_r;
  logic [PROC_W-1:0]           pid_r;
  logic [SIZE_W-1:0]           size_r;
  logic [ADDR_W-1:0]           addr_r;
  logic [BYTE_W-1:0]           wbyte_r;

  // process and frame state
  logic [dpfa_pkg::PROCS-1:0]    running_r;
  logic [SIZE_W-1:0]             bytes_r [dpfa_pkg::PROCS];
  logic [dpfa_pkg::PT_DEPTH-1:0] pt_valid_r;
  logic [dpfa_pkg::FRAMES-1:0]   frame_used_r;
  logic [RES_W-1:0]              reserved_r;
  logic [CNT_W-1:0]              cnt_r;

  // memories
  logic [FRAME_W-1:0] pt_mem [dpfa_pkg::PT_DEPTH];
  logic [FRAME_W-1:0] pt_rdata_r;
  logic [BYTE_W-1:0]  phys_mem [dpfa_pkg::PHYS_DEPTH];
  logic [BYTE_W-1:0]  phys_rdata_r;

  // result and output registers
  logic [STAT_W-1:0]  res_status_r;
  logic [PROC_W-1:0]  res_newp_r;
  logic [FRAME_W-1:0] res_frame_r;
  logic               out_valid_r;
  logic [STAT_W-1:0]  out_status_r;
  logic [PROC_W-1:0]  out_newp_r;
  logic [BYTE_W-1:0]  out_rbyte_r;
  logic [FRAME_W-1:0] out_frame_r;

  // combinational terms
  logic [PAGE_W-1:0]   page;
  logic [OFF_W-1:0]    off;
  logic                running;
  logic                is_rw;
  logic [RES_W-1:0]    need;
  logic [RES_W-1:0]    exit_pages;
  logic [RES_W:0]      budget_sum;
  logic                size_bad;
  logic                addr_bad;
  logic [PROC_W-1:0]   slot_pick;
  logic                slot_any;
  logic [STAT_W-1:0]   eval_status;
  logic                create_ok;
  logic [PT_AW-1:0]    pt_idx;
  logic [PT_AW-1:0]    pt_raddr;
  logic                present;
  logic [FRAME_W-1:0]  frame_pick;
  logic                frame_any;
  logic [FRAME_W-1:0]  map_frame;
  logic                map_ok;
  logic                alloc;
  logic [PAGE_W:0]     walk_prev;
  logic                walk_free;
  logic                walk_last;
  logic                clear_last;
  logic                phys_we;
  logic                phys_re;
  logic [PA_W-1:0]     phys_addr;
  logic [BYTE_W-1:0]   phys_wdata;

  // request decode
  assign page    = addr_r[ADDR_W-1:OFF_W];
  assign off     = addr_r[OFF_W-1:0];
  assign running = running_r[pid_r];
  assign is_rw   = (func_r == dpfa_pkg::FN_READ) || (func_r == dpfa_pkg::FN_WRITE);

  // create, address and exit checks
  assign need       = dpfa_pkg::pages_for(size_r);
  assign budget_sum = {1'b0, reserved_r} + {1'b0, need};
  assign size_bad   = (size_r == '0) || (size_r > SIZE_W'(dpfa_pkg::VIRT_BYTES));
  assign slot_any   = !(&running_r);
  assign slot_pick  = dpfa_pkg::lowest_slot(~running_r);
  assign addr_bad   = {1'b0, addr_r} >= bytes_r[pid_r];
  assign exit_pages = dpfa_pkg::pages_for(bytes_r[pid_r]);

  // status of the evaluation step
  always_comb begin
    eval_status = dpfa_pkg::ST_OK;
    case (func_r)
      dpfa_pkg::FN_CREATE: begin
        if (size_bad) begin
          eval_status = dpfa_pkg::ST_RANGE;
        end else if (budget_sum > (RES_W + 1)'(dpfa_pkg::FRAMES)) begin
          eval_status = dpfa_pkg::ST_BUDGET;
        end else if (!slot_any) begin
          eval_status = dpfa_pkg::ST_NOSLOT;
        end
      end
      dpfa_pkg::FN_EXIT: if (!running) eval_status = dpfa_pkg::ST_NOTRUN;
      default: begin
        if (!running) begin
          eval_status = dpfa_pkg::ST_NOTRUN;
        end else if (addr_bad) begin
          eval_status = dpfa_pkg::ST_RANGE;
        end
      end
    endcase
  end

  assign create_ok = cmd.eval && (func_r == dpfa_pkg::FN_CREATE) &&
                     (eval_status == dpfa_pkg::ST_OK);

  // page lookup and first-fit frame pick
  assign pt_idx     = {pid_r, page};
  assign present    = pt_valid_r[pt_idx];
  assign frame_any  = !(&frame_used_r);
  assign frame_pick = dpfa_pkg::lowest_frame(~frame_used_r);
  assign map_frame  = present ? pt_rdata_r : frame_pick;
  assign map_ok     = present || frame_any;
  assign alloc      = cmd.map && !present && frame_any;

  // exit walk: read entry n while freeing the frame of entry n-1
  assign walk_prev  = cnt_r[PAGE_W:0] - 1'b1;
  assign walk_last  = cnt_r == CNT_W'(dpfa_pkg::PAGES_PER_PROC);
  assign clear_last = cnt_r == CNT_W'(dpfa_pkg::PHYS_DEPTH - 1);
  assign walk_free  = cmd.walk && (cnt_r != '0) &&
                      pt_valid_r[{pid_r, walk_prev[PAGE_W-1:0]}];
  assign pt_raddr   = cmd.walk ? {pid_r, cnt_r[PAGE_W-1:0]} : pt_idx;

  // physical store access, clearing pass after reset
  assign phys_we    = cmd.clear || (cmd.map && map_ok && (func_r == dpfa_pkg::FN_WRITE));
  assign phys_re    = cmd.map && map_ok && (func_r == dpfa_pkg::FN_READ);
  assign phys_addr  = cmd.clear ? cnt_r : {map_frame, off};
  assign phys_wdata = cmd.clear ? '0 : wbyte_r;

  // status to the controller
  always_comb begin
    sts            = '0;
    sts.is_exit    = func_r == dpfa_pkg::FN_EXIT;
    sts.is_rw      = is_rw;
    sts.eval_err   = eval_status != dpfa_pkg::ST_OK;
    sts.walk_last  = walk_last;
    sts.clear_last = clear_last;
    sts.out_full   = out_valid_r;
  end

  // page table memory
  always_ff @(posedge clk) begin
    if (alloc) pt_mem[pt_idx] <= frame_pick;
    pt_rdata_r <= pt_mem[pt_raddr];
  end

  // physical byte store
  always_ff @(posedge clk) begin
    if (phys_we) phys_mem[phys_addr] <= phys_wdata;
    if (phys_re) phys_rdata_r <= phys_mem[phys_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r    <= '0;
      pt_valid_r   <= '0;
      frame_used_r <= '0;
      reserved_r   <= '0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      for (int p = 0; p < dpfa_pkg::PROCS; p++) begin
        bytes_r[p] <= '0;
      end
    end else begin
      // sweep counter shared by the clearing pass and the exit walk
      if (cmd.clear) begin
        cnt_r <= clear_last ? '0 : cnt_r + 1'b1;
      end else if (cmd.walk) begin
        cnt_r <= walk_last ? '0 : cnt_r + 1'b1;
      end

      // create commit
      if (create_ok) begin
        running_r[slot_pick] <= 1'b1;
        bytes_r[slot_pick]   <= size_r;
        reserved_r           <= reserved_r + need;
        for (int i = 0; i < dpfa_pkg::PAGES_PER_PROC; i++) begin
          pt_valid_r[{slot_pick, PAGE_W'(i)}] <= 1'b0;
        end
      end

      // demand mapping
      if (alloc) begin
        frame_used_r[frame_pick] <= 1'b1;
        pt_valid_r[pt_idx]       <= 1'b1;
      end

      // exit: free frames, then release the slot
      if (walk_free) frame_used_r[pt_rdata_r] <= 1'b0;
      if (cmd.walk && walk_last) begin
        for (int i = 0; i < dpfa_pkg::PAGES_PER_PROC; i++) begin
          pt_valid_r[{pid_r, PAGE_W'(i)}] <= 1'b0;
        end
        reserved_r       <= (reserved_r >= exit_pages) ? reserved_r - exit_pages : '0;
        bytes_r[pid_r]   <= '0;
        running_r[pid_r] <= 1'b0;
      end

      // output valid
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request capture, step results and output payload
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r  <= in_tuser;
      pid_r   <= in_tdata[2:0];
      size_r  <= in_tdata[12:3];
      addr_r  <= in_tdata[21:13];
      wbyte_r <= in_tdata[29:22];
    end
    if (cmd.eval) begin
      res_status_r <= eval_status;
      res_newp_r   <= create_ok ? slot_pick : '0;
      res_frame_r  <= '0;
    end
    if (cmd.map) begin
      res_status_r <= map_ok ? dpfa_pkg::ST_OK : dpfa_pkg::ST_NOFRAME;
      res_frame_r  <= map_ok ? map_frame : '0;
    end
    if (cmd.load) begin
      out_status_r <= res_status_r;
      out_newp_r   <= res_newp_r;
      out_frame_r  <= res_frame_r;
      out_rbyte_r  <= ((func_r == dpfa_pkg::FN_READ) && (res_status_r == dpfa_pkg::ST_OK)) ?
                      phys_rdata_r : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_frame_r, out_rbyte_r, out_newp_r, out_status_r};

endmodule

// ===== hw/rtl/demand_paging_frame_allocator_top.sv =====
// channel  | signals                      | direction | contents
// in_      | tvalid tready tdata tuser    | slave     | one request: op code and operands
// out_     | tvalid tready tdata          | master    | one result per request
//
// sequence: create, failed exit and failed read/write pass the EVAL and DONE states
// between accepts; read/write adds MAP; exit adds WALK, the page-table walk
// that reads one entry a cycle through the single page-table read port
// reset: a clearing pass zeroes the 1024-byte physical store, in_tready stays low
// until the clearing pass has finished
// stalls: a finished result waits in the output register while the next request is
// accepted and worked on; only its final load waits for out_tready
//
// top level of the demand paging frame allocator
// depends on dpfa_pkg, dpfa_ctrl, dpfa_datapath
module demand_paging_frame_allocator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // proc_id[2:0], request_size[12:3], virt_addr[21:13],
                                  // write_byte[29:22], zero[31:30]
  input  logic [1:0]  in_tuser,   // func[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // status[2:0], new_proc[5:3], read_byte[13:6],
                                  // phys_frame[18:14], zero[23:19]
);

  dpfa_pkg::dp_cmd_t cmd;
  dpfa_pkg::dp_sts_t sts;

  // sequencing
  dpfa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // state, memories and result register
  dpfa_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== hw/rtl/dpfa_checker.sv =====
// dpfa_checker: port-level checks of the frame allocator, bound to the top level
// depends on dpfa_pkg (status codes)
module dpfa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // one request at a time: the input closes right after an accept
  a_in_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted back to back");

  // status stays within its defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2:0] <= dpfa_pkg::ST_NOFRAME))
    else $error("status code out of range");

  // a slot number is reported only by a successful request
  a_newp_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] != dpfa_pkg::ST_OK) |-> (out_tdata[5:3] == '0))
    else $error("slot number on a failed request");

  // failed requests carry no byte and no frame
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] != dpfa_pkg::ST_OK) |->
      (out_tdata[13:6] == '0) && (out_tdata[18:14] == '0))
    else $error("data on a failed request");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

endmodule

bind demand_paging_frame_allocator_top dpfa_checker u_dpfa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/dpfa_result_checker.sv =====
// dpfa_result_checker: watches both stream channels of the frame allocator, predicts
// one result per accepted request and compares the results in order
// depends on dpfa_pkg
module dpfa_result_checker
  import dpfa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // proc_id[2:0], request_size[12:3], virt_addr[21:13],
                                  // write_byte[29:22], zero[31:30]
  input  logic [1:0]  in_tuser,   // func[1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // status[2:0], new_proc[5:3], read_byte[13:6],
                                  // phys_frame[18:14], zero[23:19]
  output int          mismatch_total,
  output int          results_pending
);

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [PROC_W-1:0]  new_proc;
    logic [BYTE_W-1:0]  read_byte;
    logic [FRAME_W-1:0] phys_frame;
  } outcome_t;

  // shadow of the allocator state
  logic       slot_live   [PROCS];
  int         slot_bytes  [PROCS];
  logic       page_mapped [PT_DEPTH];
  int         page_frame  [PT_DEPTH];
  logic       frame_taken [FRAMES];
  int         reserved_pages;
  logic [7:0] frame_bytes [PHYS_DEPTH];

  outcome_t outcome_q[$];
  outcome_t oldest;
  int       errors = 0;

  initial begin
    mismatch_total  = 0;
    results_pending = 0;
  end

  // apply one request to the shadow state and return its result
  function automatic outcome_t allocator_outcome(input logic [FUNC_W-1:0] fn,
                                                 input logic [PROC_W-1:0] pid,
                                                 input logic [SIZE_W-1:0] size,
                                                 input logic [ADDR_W-1:0] addr,
                                                 input logic [BYTE_W-1:0] wbyte);
    outcome_t res;
    int       need;
    int       base;
    int       idx;
    int       pa;
    bit       placed;
    res  = '0;
    base = int'(pid) * PAGES_PER_PROC;
    case (fn)
      FN_CREATE: begin
        need = (int'(size) + PAGE_BYTES - 1) / PAGE_BYTES;
        if (size == '0 || int'(size) > VIRT_BYTES) begin
          res.status = ST_RANGE;
        end else if (reserved_pages + need > FRAMES) begin
          res.status = ST_BUDGET;
        end else begin
          // lowest free slot, all its pages start unmapped
          res.status = ST_NOSLOT;
          placed     = 1'b0;
          for (int p = 0; p < PROCS; p++) begin
            if (!placed && !slot_live[p]) begin
              placed          = 1'b1;
              slot_live[p]    = 1'b1;
              slot_bytes[p]   = int'(size);
              reserved_pages += need;
              for (int i = 0; i < PAGES_PER_PROC; i++) begin
                page_mapped[p * PAGES_PER_PROC + i] = 1'b0;
                page_frame[p * PAGES_PER_PROC + i]  = 0;
              end
              res.status   = ST_OK;
              res.new_proc = PROC_W'(p);
            end
          end
        end
      end
      FN_EXIT: begin
        if (!slot_live[pid]) begin
          res.status = ST_NOTRUN;
        end else begin
          // release mapped frames and the page budget
          for (int i = 0; i < PAGES_PER_PROC; i++) begin
            if (page_mapped[base + i]) frame_taken[page_frame[base + i]] = 1'b0;
            page_mapped[base + i] = 1'b0;
            page_frame[base + i]  = 0;
          end
          need = (slot_bytes[pid] + PAGE_BYTES - 1) / PAGE_BYTES;
          reserved_pages  = (reserved_pages >= need) ? reserved_pages - need : 0;
          slot_bytes[pid] = 0;
          slot_live[pid]  = 1'b0;
        end
      end
      default: begin
        if (!slot_live[pid]) begin
          res.status = ST_NOTRUN;
        end else if (int'(addr) >= slot_bytes[pid]) begin
          res.status = ST_RANGE;
        end else begin
          idx = base + int'(addr) / PAGE_BYTES;
          // demand mapping, first free frame; old contents stay
          for (int f = 0; f < FRAMES; f++) begin
            if (!page_mapped[idx] && !frame_taken[f]) begin
              frame_taken[f]   = 1'b1;
              page_mapped[idx] = 1'b1;
              page_frame[idx]  = f;
            end
          end
          if (!page_mapped[idx]) begin
            res.status = ST_NOFRAME;
          end else begin
            pa = page_frame[idx] * PAGE_BYTES + int'(addr) % PAGE_BYTES;
            if (fn == FN_READ) res.read_byte = frame_bytes[pa];
            else frame_bytes[pa] = wbyte;
            res.phys_frame = FRAME_W'(page_frame[idx]);
          end
        end
      end
    endcase
    return res;
  endfunction

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // results are popped before requests are pushed within one edge
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < PROCS; p++) begin
        slot_live[p]  = 1'b0;
        slot_bytes[p] = 0;
      end
      for (int i = 0; i < PT_DEPTH; i++) begin
        page_mapped[i] = 1'b0;
        page_frame[i]  = 0;
      end
      for (int f = 0; f < FRAMES; f++) frame_taken[f] = 1'b0;
      for (int a = 0; a < PHYS_DEPTH; a++) frame_bytes[a] = '0;
      reserved_pages = 0;
      outcome_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (outcome_q.size() == 0) begin
          errors++;
          $display("%0t unexpected result: expected none, actual 0x%06h", $time, out_tdata);
        end else begin
          oldest = outcome_q.pop_front();
          compare_field("status", oldest.status, out_tdata[2:0]);
          compare_field("new_proc", oldest.new_proc, out_tdata[5:3]);
          compare_field("read_byte", oldest.read_byte, out_tdata[13:6]);
          compare_field("phys_frame", oldest.phys_frame, out_tdata[18:14]);
          compare_field("padding", 0, out_tdata[23:19]);
        end
      end
      if (in_tvalid && in_tready) begin
        outcome_q.push_back(allocator_outcome(in_tuser, in_tdata[2:0], in_tdata[12:3],
                                              in_tdata[21:13], in_tdata[29:22]));
      end
    end
    results_pending <= outcome_q.size();
    mismatch_total  <= errors;
  end

endmodule

// ===== tb/tb_demand_paging_frame_allocator_top.sv =====
// tb_demand_paging_frame_allocator_top: clock, reset, directed and random requests with
// random stalls on both channels, watchdog and verdict for the frame allocator
// depends on dpfa_pkg, demand_paging_frame_allocator_top, dpfa_result_checker
module tb_demand_paging_frame_allocator_top;
  import dpfa_pkg::*;

  localparam int STALL_LIMIT     = 4000;
  localparam int ITEMS_PER_PHASE = 610;
  localparam int SETTLE_CYCLES   = 40;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [31:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [23:0] out_tdata;

  int in_idle_pct  = 27;
  int out_idle_pct = 86;
  int quiet_cycles = 0;
  int mismatches;
  int outstanding;

  always #4 clk = ~clk;

  demand_paging_frame_allocator_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  dpfa_result_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .mismatch_total  (mismatches),
    .results_pending (outstanding)
  );

  // receiver backpressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_demand_paging_frame_allocator_top: FAIL");
        $finish;
      end
    end
  end

  // present one request, with random idle cycles ahead of it
  task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [PROC_W-1:0] pid,
                              input logic [SIZE_W-1:0] size, input logic [ADDR_W-1:0] addr,
                              input logic [BYTE_W-1:0] wbyte);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, wbyte, addr, size, pid};
    in_tuser  <= fn;
    do @(posedge clk); while (!in_tready);
  endtask

  // hold off until every result has come back
  task automatic drain_results;
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // mostly well-formed traffic: small processes, addresses near the bottom
  task automatic random_request;
    int                  pick;
    int                  shape;
    logic [FUNC_W-1:0]   fn;
    logic [PROC_W-1:0]   pid;
    logic [SIZE_W-1:0]   size;
    logic [ADDR_W-1:0]   addr;
    logic [BYTE_W-1:0]   wbyte;
    pick  = $urandom_range(99);
    shape = $urandom_range(99);
    pid   = PROC_W'($urandom);
    size  = SIZE_W'($urandom);
    addr  = ADDR_W'($urandom);
    wbyte = BYTE_W'($urandom);
    if (pick < 10) begin
      fn = FN_CREATE;
      if (shape < 70) size = SIZE_W'($urandom_range(1, 128));
      else if (shape < 85) size = SIZE_W'($urandom_range(129, VIRT_BYTES));
      else if (shape < 92) size = SIZE_W'(VIRT_BYTES);
      else if (shape < 95) size = '0;
    end else if (pick < 16) begin
      fn = FN_EXIT;
    end else begin
      fn = (pick < 55) ? FN_READ : FN_WRITE;
      if (shape < 60) addr = ADDR_W'($urandom_range(0, 63));
      else if (shape < 85) addr = ADDR_W'($urandom_range(0, 160));
    end
    send_request(fn, pid, size, addr, wbyte);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // slot not running, bad sizes, budget filled by two full processes
    send_request(FN_READ,   3'd0, '0,      9'd0,   8'h00);
    send_request(FN_EXIT,   3'd7, '0,      9'd0,   8'h00);
    send_request(FN_CREATE, 3'd0, 10'd0,   9'd0,   8'h00);
    send_request(FN_CREATE, 3'd0, 10'd1023, 9'd0,  8'h00);
    send_request(FN_CREATE, 3'd0, 10'd513, 9'd0,   8'h00);
    send_request(FN_CREATE, 3'd0, 10'd512, 9'd0,   8'h00);
    send_request(FN_CREATE, 3'd0, 10'd512, 9'd0,   8'h00);
    send_request(FN_CREATE, 3'd0, 10'd1,   9'd0,   8'h00);
    // demand mapping at both ends of the space
    send_request(FN_WRITE,  3'd0, '0,      9'd511, 8'hFF);
    send_request(FN_READ,   3'd0, '0,      9'd511, 8'h00);
    send_request(FN_READ,   3'd0, '0,      9'd0,   8'h00);
    send_request(FN_WRITE,  3'd1, '0,      9'd256, 8'h5A);
    send_request(FN_READ,   3'd1, '0,      9'd256, 8'h00);
    // exit, then reuse of freed frames and out-of-range access
    send_request(FN_EXIT,   3'd0, '0,      9'd0,   8'h00);
    send_request(FN_CREATE, 3'd0, 10'd1,   9'd0,   8'h00);
    send_request(FN_READ,   3'd0, '0,      9'd1,   8'h00);
    send_request(FN_READ,   3'd0, '0,      9'd0,   8'h00);
    // fill every slot, then one more
    repeat (6) send_request(FN_CREATE, 3'd0, 10'd1, 9'd0, 8'h00);
    send_request(FN_CREATE, 3'd0, 10'd1, 9'd0, 8'h00);
    drain_results;

    // three stall profiles
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin in_idle_pct = 27; out_idle_pct = 86; end
        1: begin in_idle_pct = 86; out_idle_pct = 27; end
        default: begin in_idle_pct = 0; out_idle_pct = 0; end
      endcase
      repeat (ITEMS_PER_PHASE) random_request();
      drain_results;
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_demand_paging_frame_allocator_top: PASS");
    end else begin
      $display("tb_demand_paging_frame_allocator_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/dpfa_pkg.sv
hw/rtl/dpfa_ctrl.sv
hw/rtl/dpfa_datapath.sv
hw/rtl/demand_paging_frame_allocator_top.sv
hw/rtl/dpfa_checker.sv
tb/dpfa_result_checker.sv
tb/tb_demand_paging_frame_allocator_top.sv
